[hw/rtl/afib_pkg.sv]
// Package for the audio frame index builder: payload structs, register
// indexes, controller states, commands and shared constants.
// No dependencies.
`default_nettype none

package afib_pkg;

	// widths of the descriptor fields and of internal values
	localparam int WORD_W  = 32;
	localparam int BIT_W   = 8;
	localparam int SKIP_W  = 9;
	localparam int TIME_W  = 64;
	localparam int REST_W  = 35;   // file_size - offset - tail, signed
	localparam int CFG_A_W = 3;

	// microseconds per second, and the width of blocks * 1000000
	localparam int US_W = 20;
	localparam logic [US_W-1:0] US_PER_SEC = 20'd1000000;
	localparam int DIV_W     = WORD_W + US_W;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	localparam logic [WORD_W-1:0] BPF_RESET   = 32'd73728;
	localparam logic [WORD_W-1:0] RATE_RESET  = 32'd44100;
	localparam logic [WORD_W-1:0] TOTAL_RESET = 32'd1;
	localparam logic [WORD_W-1:0] ALIGN_MASK  = 32'h3;
	localparam logic [WORD_W-1:0] OLD_BONUS   = 32'd4;

	typedef struct packed {
		logic [WORD_W-1:0] table_offset;
		logic [BIT_W-1:0]  bit_value;
	} in_word_t;

	typedef struct packed {
		logic [WORD_W-1:0] frame_index;
		logic [WORD_W-1:0] frame_offset;
		logic [WORD_W-1:0] frame_size;
		logic [SKIP_W-1:0] frame_skip;
		logic [WORD_W-1:0] frame_blocks;
		logic [TIME_W-1:0] frame_timestamp;
		logic              last_frame;
	} out_word_t;

	typedef enum logic [CFG_A_W-1:0] {
		CFG_DATA_START   = 3'd0,
		CFG_BLOCKS       = 3'd1,
		CFG_FINAL_BLOCKS = 3'd2,
		CFG_SAMPLE_RATE  = 3'd3,
		CFG_OLD_FORMAT   = 3'd4,
		CFG_TOTAL_FRAMES = 3'd5,
		CFG_FILE_SIZE    = 3'd6,
		CFG_WAVE_TAIL    = 3'd7
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MID_SIZE,
		ST_MID_BUILD,
		ST_MID_WAIT,
		ST_LAST_OFF,
		ST_LAST_REST,
		ST_LAST_TAIL,
		ST_LAST_BUILD,
		ST_LAST_WAIT,
		ST_FINISH
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_ACCEPT,
		CMD_MID_SIZE,
		CMD_MID_BUILD,
		CMD_LAST_OFF,
		CMD_LAST_REST,
		CMD_LAST_TAIL,
		CMD_LAST_BUILD,
		CMD_ACCUM,
		CMD_FINISH
	} cmd_t;

	typedef struct packed {
		logic has_mid;    // a pending frame waits for its descriptor
		logic is_last;    // current entry is the final frame
		logic run_done;   // all frames consumed, entries are dropped
		logic out_free;   // output register can take a word this cycle
		logic div_busy;   // timestamp divider still iterating
	} status_t;

endpackage

`default_nettype wire

[hw/rtl/afib_div.sv]
// Restoring divider for the timestamp increment: blocks * 1000000 / rate,
// one quotient bit per cycle. Depends on afib_pkg.
`default_nettype none

module afib_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [afib_pkg::WORD_W-1:0]    blocks,
	input  wire logic [afib_pkg::WORD_W-1:0]    rate,
	output logic                                busy,
	output logic [afib_pkg::DIV_W-1:0]          quot
);

	logic [afib_pkg::DIV_W-1:0]     dvd_q;    // dividend in, quotient out
	logic [afib_pkg::WORD_W-1:0]    rem_q;
	logic [afib_pkg::WORD_W-1:0]    dsr_q;
	logic [afib_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;

	logic [afib_pkg::DIV_W-1:0]     prod;
	logic [afib_pkg::WORD_W:0]      trial;
	logic [afib_pkg::WORD_W:0]      diff;
	logic                           qbit;

	assign prod  = {{afib_pkg::US_W{1'b0}}, blocks}
	             * {{afib_pkg::WORD_W{1'b0}}, afib_pkg::US_PER_SEC};
	assign trial = {rem_q, dvd_q[afib_pkg::DIV_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign qbit  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= afib_pkg::DIV_CNT_W'(afib_pkg::DIV_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != afib_pkg::DIV_CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= prod;
			rem_q <= '0;
			dsr_q <= rate;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[afib_pkg::WORD_W-1:0] : trial[afib_pkg::WORD_W-1:0];
			dvd_q <= {dvd_q[afib_pkg::DIV_W-2:0], qbit};
		end
	end

	assign busy = busy_q;
	assign quot = dvd_q;

endmodule

`default_nettype wire

[hw/rtl/afib_ctrl.sv]
// Controller for the frame index builder: sequences accept, descriptor
// builds and divider waits. Depends on afib_pkg.
`default_nettype none

module afib_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire afib_pkg::status_t st,
	output logic                   in_stall,
	output afib_pkg::cmd_t         cmd
);

	afib_pkg::state_t state_q;
	afib_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= afib_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			afib_pkg::ST_IDLE: begin
				if (in_valid && !st.run_done) begin
					if (st.has_mid)
						state_nx = afib_pkg::ST_MID_SIZE;
					else if (st.is_last)
						state_nx = afib_pkg::ST_LAST_OFF;
					else
						state_nx = afib_pkg::ST_FINISH;
				end
			end
			afib_pkg::ST_MID_SIZE:  state_nx = afib_pkg::ST_MID_BUILD;
			afib_pkg::ST_MID_BUILD: begin
				if (st.out_free)
					state_nx = afib_pkg::ST_MID_WAIT;
			end
			afib_pkg::ST_MID_WAIT: begin
				if (!st.div_busy)
					state_nx = st.is_last ? afib_pkg::ST_LAST_OFF : afib_pkg::ST_FINISH;
			end
			afib_pkg::ST_LAST_OFF:  state_nx = afib_pkg::ST_LAST_REST;
			afib_pkg::ST_LAST_REST: state_nx = afib_pkg::ST_LAST_TAIL;
			afib_pkg::ST_LAST_TAIL: state_nx = afib_pkg::ST_LAST_BUILD;
			afib_pkg::ST_LAST_BUILD: begin
				if (st.out_free)
					state_nx = afib_pkg::ST_LAST_WAIT;
			end
			afib_pkg::ST_LAST_WAIT: begin
				if (!st.div_busy)
					state_nx = afib_pkg::ST_FINISH;
			end
			afib_pkg::ST_FINISH: state_nx = afib_pkg::ST_IDLE;
			default:             state_nx = afib_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = afib_pkg::CMD_NONE;
		in_stall = 1'b1;
		case (state_q)
			afib_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && !st.run_done)
					cmd = afib_pkg::CMD_ACCEPT;
			end
			afib_pkg::ST_MID_SIZE: cmd = afib_pkg::CMD_MID_SIZE;
			afib_pkg::ST_MID_BUILD: begin
				if (st.out_free)
					cmd = afib_pkg::CMD_MID_BUILD;
			end
			afib_pkg::ST_MID_WAIT, afib_pkg::ST_LAST_WAIT: begin
				if (!st.div_busy)
					cmd = afib_pkg::CMD_ACCUM;
			end
			afib_pkg::ST_LAST_OFF:  cmd = afib_pkg::CMD_LAST_OFF;
			afib_pkg::ST_LAST_REST: cmd = afib_pkg::CMD_LAST_REST;
			afib_pkg::ST_LAST_TAIL: cmd = afib_pkg::CMD_LAST_TAIL;
			afib_pkg::ST_LAST_BUILD: begin
				if (st.out_free)
					cmd = afib_pkg::CMD_LAST_BUILD;
			end
			afib_pkg::ST_FINISH: cmd = afib_pkg::CMD_FINISH;
			default:             cmd = afib_pkg::CMD_NONE;
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/afib_dp.sv]
// Datapath for the frame index builder: config registers, frame state,
// size and offset arithmetic, output register and the timestamp divider.
// Depends on afib_pkg and afib_div.
`default_nettype none

module afib_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write,
	input  wire logic [afib_pkg::CFG_A_W-1:0]  cfg_index,
	input  wire logic [afib_pkg::WORD_W-1:0]   cfg_data,
	input  wire afib_pkg::in_word_t            in_data,
	input  wire logic                          out_stall,
	input  wire afib_pkg::cmd_t                cmd,
	output afib_pkg::status_t                  st,
	output logic                               out_valid,
	output afib_pkg::out_word_t                out_data
);

	localparam int W = afib_pkg::WORD_W;

	// configuration
	logic [W-1:0] data_start_q, bpf_q, final_blocks_q, rate_q;
	logic [W-1:0] total_q, file_size_q, wave_tail_q;
	logic         old_fmt_q;

	// run state
	logic [W-1:0]                  frames_seen_q;
	logic [W-1:0]                  prev_raw_q;
	logic [afib_pkg::SKIP_W-1:0]   prev_skip_q;
	logic [afib_pkg::TIME_W-1:0]   time_accum_q;

	// current entry and temporaries
	logic [W-1:0]                  raw_q;
	logic [afib_pkg::SKIP_W-1:0]   skip_q;
	logic [afib_pkg::BIT_W-1:0]    bit_q;
	logic [W-1:0]                  tmp_q;
	logic [W-1:0]                  off_q;
	logic signed [afib_pkg::REST_W-1:0] rest_q;

	logic                          out_valid_q;
	afib_pkg::out_word_t           out_q;

	logic [W-1:0]                  total_eff;
	logic [W-1:0]                  raw_in;
	logic [1:0]                    align;
	logic [afib_pkg::SKIP_W-1:0]   skip_in;
	logic [W-1:0]                  mid_size;
	logic [W-1:0]                  last_size;
	logic                          div_start;
	logic [W-1:0]                  div_blocks;
	logic                          div_busy;
	logic [afib_pkg::DIV_W-1:0]    quot;
	logic                          out_take;

	assign total_eff = (total_q == '0) ? afib_pkg::TOTAL_RESET : total_q;

	assign st.has_mid  = (frames_seen_q != '0);
	assign st.is_last  = (frames_seen_q == total_eff - 1'b1);
	assign st.run_done = (frames_seen_q >= total_eff);
	assign st.out_free = !out_valid_q || !out_stall;
	assign st.div_busy = div_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_start_q   <= '0;
			bpf_q          <= afib_pkg::BPF_RESET;
			final_blocks_q <= '0;
			rate_q         <= afib_pkg::RATE_RESET;
			old_fmt_q      <= 1'b0;
			total_q        <= afib_pkg::TOTAL_RESET;
			file_size_q    <= '0;
			wave_tail_q    <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				afib_pkg::CFG_DATA_START:   data_start_q   <= cfg_data;
				afib_pkg::CFG_BLOCKS:       bpf_q          <= cfg_data;
				afib_pkg::CFG_FINAL_BLOCKS: final_blocks_q <= cfg_data;
				afib_pkg::CFG_SAMPLE_RATE:  rate_q         <= cfg_data;
				afib_pkg::CFG_OLD_FORMAT:   old_fmt_q      <= cfg_data[0];
				afib_pkg::CFG_TOTAL_FRAMES: total_q        <= cfg_data;
				afib_pkg::CFG_FILE_SIZE:    file_size_q    <= cfg_data;
				afib_pkg::CFG_WAVE_TAIL:    wave_tail_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame 0 starts at data_start; alignment only needs the low two bits
	assign raw_in  = st.has_mid ? in_data.table_offset : data_start_q;
	assign align   = raw_in[1:0] - data_start_q[1:0];
	assign skip_in = old_fmt_q ? ({4'd0, align, 3'd0} + {1'b0, in_data.bit_value})
	                           : {7'd0, align};

	assign mid_size  = (tmp_q + {23'd0, prev_skip_q} + 32'd3) & ~afib_pkg::ALIGN_MASK;
	assign last_size = (rest_q < 35'sd4) ? (final_blocks_q << 3)
	                                     : (rest_q[W-1:0] & ~afib_pkg::ALIGN_MASK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_seen_q <= '0;
			prev_raw_q    <= '0;
			prev_skip_q   <= '0;
			time_accum_q  <= '0;
		end else begin
			case (cmd)
				afib_pkg::CMD_ACCUM: begin
					if (rate_q != '0)
						time_accum_q <= time_accum_q
						              + {{(afib_pkg::TIME_W-afib_pkg::DIV_W){1'b0}}, quot};
				end
				afib_pkg::CMD_FINISH: begin
					frames_seen_q <= frames_seen_q + 1'b1;
					prev_raw_q    <= raw_q;
					prev_skip_q   <= skip_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			afib_pkg::CMD_ACCEPT: begin
				raw_q  <= raw_in;
				skip_q <= skip_in;
				bit_q  <= in_data.bit_value;
			end
			afib_pkg::CMD_MID_SIZE: begin
				tmp_q <= raw_q - prev_raw_q
				       + ((old_fmt_q && bit_q != '0) ? afib_pkg::OLD_BONUS : '0);
			end
			afib_pkg::CMD_LAST_OFF:  off_q  <= raw_q - {23'd0, skip_q};
			afib_pkg::CMD_LAST_REST: rest_q <= $signed({3'd0, file_size_q})
			                                 - $signed({3'd0, off_q});
			afib_pkg::CMD_LAST_TAIL: rest_q <= rest_q - $signed({3'd0, wave_tail_q});
			default: ;
		endcase
	end

	// output register; builds only happen when it is free
	assign out_take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd == afib_pkg::CMD_MID_BUILD || cmd == afib_pkg::CMD_LAST_BUILD) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			afib_pkg::CMD_MID_BUILD: begin
				out_q.frame_index     <= frames_seen_q - 1'b1;
				out_q.frame_offset    <= prev_raw_q - {23'd0, prev_skip_q};
				out_q.frame_size      <= mid_size;
				out_q.frame_skip      <= prev_skip_q;
				out_q.frame_blocks    <= bpf_q;
				out_q.frame_timestamp <= time_accum_q;
				out_q.last_frame      <= 1'b0;
			end
			afib_pkg::CMD_LAST_BUILD: begin
				out_q.frame_index     <= frames_seen_q;
				out_q.frame_offset    <= off_q;
				out_q.frame_size      <= last_size;
				out_q.frame_skip      <= skip_q;
				out_q.frame_blocks    <= final_blocks_q;
				out_q.frame_timestamp <= time_accum_q;
				out_q.last_frame      <= 1'b1;
			end
			default: ;
		endcase
	end

	assign div_start  = (cmd == afib_pkg::CMD_MID_BUILD) || (cmd == afib_pkg::CMD_LAST_BUILD);
	assign div_blocks = (cmd == afib_pkg::CMD_LAST_BUILD) ? final_blocks_q : bpf_q;

	afib_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.blocks (div_blocks),
		.rate   (rate_q),
		.busy   (div_busy),
		.quot   (quot)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

[hw/rtl/audio_frame_index_builder.sv]
// Top level of the audio frame index builder: controller plus datapath.
// Depends on afib_pkg, afib_ctrl, afib_dp (which holds afib_div).
//
//   port group   direction   payload                  handshake
//   in_*         in          afib_pkg::in_word_t      in_valid / in_stall
//   out_*        out         afib_pkg::out_word_t     out_valid / out_stall
//   cfg_*        in          3-bit index, 32-bit data cfg_write
//
// One entry at a time. An entry that completes no descriptor is accepted and then finished.
// Each descriptor waits on the 52-step bit-serial divider that forms the timestamp
// increment, so an entry that closes the pending frame waits once, a lone final
// entry once, and a final entry that also closes the pending frame twice.
// Entries after the run ends are taken and dropped.
// arst_n clears config to its defaults and the run state to zero.
// A stalled output holds its word; the next entry is still taken meanwhile.
`default_nettype none

module audio_frame_index_builder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write,
	input  wire logic [afib_pkg::CFG_A_W-1:0]  cfg_index,
	input  wire logic [afib_pkg::WORD_W-1:0]   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire afib_pkg::in_word_t            in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output afib_pkg::out_word_t                out_data
);

	afib_pkg::cmd_t    cmd;
	afib_pkg::status_t st;

	afib_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.st       (st),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	afib_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_stall (out_stall),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// a descriptor is never built over a word still waiting at the output
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == afib_pkg::CMD_MID_BUILD || cmd == afib_pkg::CMD_LAST_BUILD)
		|-> (!out_valid || !out_stall))
		else $error("descriptor built over pending output word");

	// divider is idle whenever it is started
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == afib_pkg::CMD_MID_BUILD || cmd == afib_pkg::CMD_LAST_BUILD)
		|-> !st.div_busy)
		else $error("divider restarted while busy");

	// taking entries means no timestamp work is left over
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !st.div_busy)
		else $error("input open while divider busy");

	a_skip_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.frame_skip <= 9'd279))
		else $error("frame skip out of range");

endmodule

`default_nettype wire
